// ===== rtl/msmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// msmfc_pkg
// shared types and constants of the music fade controller
// ----------------------------------------------------------------------------
package msmfc_pkg;

    localparam logic [15:0] FULL_SCALE  = 16'd32768;
    localparam logic [15:0] RATIO_FLOOR = 16'd3277;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_FADE_IN   = 3'd1,
        MODE_PLAY      = 3'd2,
        MODE_FADE_OUT  = 3'd3,
        MODE_FADE_LIMIT = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_FADE_IN    = 4'd1,
        OP_FADE_OUT   = 4'd2,
        OP_FADE_LIMIT = 4'd3,
        OP_SET_VOLUME = 4'd4,
        OP_PLAY       = 4'd5,
        OP_FADE_ALL   = 4'd6,
        OP_MUTE       = 4'd7,
        OP_RESTORE    = 4'd8
    } opcode_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_KEY  = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] name_key;
        logic [15:0] ramp_rate;
        logic [15:0] level;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic [2:0]  slot_mode;
        logic [15:0] slot_level;
        logic        stopped_now;
        logic [1:0]  status;
        logic        is_last;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // latch the input word
        logic scan;       // search pass on the current slot
        logic apply;      // update pass on the current slot
        logic finish;     // global register update at end of apply
        logic [3:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] status;
    } dp_stat_t;

    function automatic logic [15:0] sat_q15(input logic [15:0] v);
        sat_q15 = (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

    function automatic logic [15:0] pow_curve(input logic [5:0] i);
        case (i)
            6'd0:  pow_curve = 16'd3277;   6'd1:  pow_curve = 16'd3521;
            6'd2:  pow_curve = 16'd3784;   6'd3:  pow_curve = 16'd4066;
            6'd4:  pow_curve = 16'd4370;   6'd5:  pow_curve = 16'd4696;
            6'd6:  pow_curve = 16'd5046;   6'd7:  pow_curve = 16'd5423;
            6'd8:  pow_curve = 16'd5827;   6'd9:  pow_curve = 16'd6262;
            6'd10: pow_curve = 16'd6729;   6'd11: pow_curve = 16'd7231;
            6'd12: pow_curve = 16'd7771;   6'd13: pow_curve = 16'd8350;
            6'd14: pow_curve = 16'd8973;   6'd15: pow_curve = 16'd9643;
            6'd16: pow_curve = 16'd10362;  6'd17: pow_curve = 16'd11135;
            6'd18: pow_curve = 16'd11966;  6'd19: pow_curve = 16'd12859;
            6'd20: pow_curve = 16'd13818;  6'd21: pow_curve = 16'd14849;
            6'd22: pow_curve = 16'd15957;  6'd23: pow_curve = 16'd17147;
            6'd24: pow_curve = 16'd18427;  6'd25: pow_curve = 16'd19802;
            6'd26: pow_curve = 16'd21279;  6'd27: pow_curve = 16'd22867;
            6'd28: pow_curve = 16'd24573;  6'd29: pow_curve = 16'd26406;
            6'd30: pow_curve = 16'd28376;  6'd31: pow_curve = 16'd30493;
            default: pow_curve = 16'd32768;
        endcase
    endfunction

endpackage

// ===== rtl/msmfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// msmfc_ctrl
// sequencer: load, search pass, apply pass, then one output word per slot
// ----------------------------------------------------------------------------
module msmfc_ctrl #(
    parameter int SLOTS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_valid_q,
    input  logic              out_stall,
    output msmfc_pkg::dp_cmd_t cmd,
    output logic              emit
);
    import msmfc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_APPLY, S_EMIT } state_t;

    state_t        state_reg;
    logic [SW-1:0] slot_reg;

    logic out_free;
    assign out_free = !out_valid_q || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.slot   = 4'(slot_reg);
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.apply  = (state_reg == S_APPLY);
        cmd.finish = (state_reg == S_APPLY) && (slot_reg == LAST);
        emit       = (state_reg == S_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    slot_reg <= '0;
                    if (in_valid)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (slot_reg == LAST)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_APPLY;
                    end
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                S_APPLY:
                begin
                    if (slot_reg == LAST)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (slot_reg == LAST)
                            state_reg <= S_IDLE;
                        else
                            slot_reg <= slot_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/msmfc_dp.sv =====
// ----------------------------------------------------------------------------
// msmfc_dp
// slot tables, key search, per-slot update and output register
// ----------------------------------------------------------------------------
module msmfc_dp #(
    parameter int SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  msmfc_pkg::in_word_t  in_word,
    input  msmfc_pkg::dp_cmd_t   cmd,
    input  logic                 emit,
    input  logic                 out_stall,
    output logic                 out_valid_q,
    output msmfc_pkg::out_word_t out_word
);
    import msmfc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [2:0]  mode_reg  [SLOTS];
    logic [15:0] level_reg [SLOTS];
    logic [15:0] rate_reg  [SLOTS];
    logic [15:0] limit_reg [SLOTS];
    logic [31:0] key_reg   [SLOTS];
    logic [SLOTS-1:0] stop_reg;

    logic [15:0] fade_all_reg, master_reg, saved_reg;
    logic        muted_reg;

    logic [3:0]  op_reg;
    logic [31:0] key_in_reg;
    logic [15:0] rate_in_reg, lvl_in_reg;

    logic        found_reg, free_found_reg;
    logic [SW-1:0] found_slot_reg, free_slot_reg;
    logic [15:0] limit_new_reg;

    logic [SW-1:0] cur;
    assign cur = cmd.slot[SW-1:0];

    // status follows from the search result
    logic [1:0] status;
    always_comb
    begin
        status = ST_OK;
        if ((op_reg == OP_FADE_OUT || op_reg == OP_FADE_LIMIT) && !found_reg)
            status = ST_NO_KEY;
        if (op_reg == OP_FADE_IN && !found_reg && !free_found_reg)
            status = ST_NO_SLOT;
    end

    // master value applied by set volume style opcodes
    logic        do_master;
    logic [15:0] master_v;
    always_comb
    begin
        do_master = 1'b0;
        master_v  = lvl_in_reg;
        case (op_reg)
            OP_SET_VOLUME: do_master = !muted_reg;
            OP_MUTE:
            begin
                do_master = !muted_reg;
                master_v  = '0;
            end
            OP_RESTORE:
            begin
                do_master = 1'b1;
                master_v  = saved_reg;
            end
            default: do_master = 1'b0;
        endcase
    end

    // limit curve interpolation, computed in the first search cycle
    logic [15:0] c_lo, c_hi;
    logic [25:0] c_prod;
    logic [15:0] limit_calc;
    always_comb
    begin
        c_lo   = pow_curve({1'b0, lvl_in_reg[14:10]});
        c_hi   = pow_curve({1'b0, lvl_in_reg[14:10]} + 6'd1);
        c_prod = (c_hi - c_lo) * lvl_in_reg[9:0] + 26'd512;
        if (lvl_in_reg < RATIO_FLOOR)
            limit_calc = lvl_in_reg;
        else if (lvl_in_reg[15])
            limit_calc = FULL_SCALE;
        else
            limit_calc = c_lo + c_prod[25:10];
    end

    // per-slot next value in the apply pass
    logic [2:0]  m, m_n;
    logic [15:0] l_n, r_n, lim_n;
    logic [31:0] k_n;
    logic        stop_n;
    logic [16:0] sum;
    logic signed [17:0] diff;
    always_comb
    begin
        m      = mode_reg[cur];
        m_n    = m;
        l_n    = level_reg[cur];
        r_n    = rate_reg[cur];
        lim_n  = limit_reg[cur];
        k_n    = key_reg[cur];
        stop_n = 1'b0;
        sum    = {1'b0, level_reg[cur]} + {1'b0, rate_reg[cur]};
        diff   = $signed({2'b00, level_reg[cur]}) - $signed({2'b00, rate_reg[cur]});
        case (op_reg)
            OP_TICK:
            begin
                if (m == MODE_FADE_IN)
                begin
                    if (sum >= {1'b0, master_reg})
                    begin
                        l_n = master_reg; r_n = '0; m_n = MODE_PLAY;
                    end
                    else
                        l_n = sum[15:0];
                end
                else if (m == MODE_FADE_LIMIT)
                begin
                    if (diff <= $signed({2'b00, limit_reg[cur]}))
                    begin
                        l_n = limit_reg[cur]; r_n = '0; m_n = MODE_PLAY;
                    end
                    else
                        l_n = diff[15:0];
                end
                else if (m == MODE_FADE_OUT)
                begin
                    if (diff <= 18'sd0)
                    begin
                        l_n = '0; r_n = '0; m_n = MODE_OFF; k_n = '0; stop_n = 1'b1;
                    end
                    else
                        l_n = diff[15:0];
                end
            end
            OP_FADE_IN:
            begin
                if (found_reg)
                begin
                    if (found_slot_reg == cur)
                    begin
                        m_n = MODE_FADE_IN; r_n = rate_in_reg;
                    end
                end
                else if (m != MODE_OFF)
                begin
                    m_n = MODE_FADE_OUT; r_n = fade_all_reg;
                end
                else if (free_found_reg && free_slot_reg == cur)
                begin
                    l_n = '0; r_n = rate_in_reg; m_n = MODE_FADE_IN; k_n = key_in_reg;
                end
            end
            OP_FADE_OUT:
                if (found_reg && found_slot_reg == cur)
                begin
                    m_n = MODE_FADE_OUT; r_n = rate_in_reg;
                end
            OP_FADE_LIMIT:
                if (found_reg && found_slot_reg == cur)
                begin
                    m_n = MODE_FADE_LIMIT; r_n = rate_in_reg; lim_n = limit_new_reg;
                end
            OP_PLAY:
                if (cur == '0)
                begin
                    l_n = master_reg; r_n = '0; m_n = MODE_FADE_IN; k_n = key_in_reg;
                end
            OP_FADE_ALL:
                if (m != MODE_OFF)
                begin
                    m_n = MODE_FADE_OUT; r_n = fade_all_reg;
                end
            default:
                if (do_master && m != MODE_OFF && m != MODE_FADE_OUT)
                    l_n = master_v;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i]  <= MODE_OFF;
                level_reg[i] <= '0;
                rate_reg[i]  <= '0;
                limit_reg[i] <= '0;
                key_reg[i]   <= '0;
            end
            stop_reg       <= '0;
            fade_all_reg   <= 16'd328;
            master_reg     <= FULL_SCALE;
            saved_reg      <= '0;
            muted_reg      <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_q    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fade_all_reg <= sat_q15(cfg_data);
            if (cmd.load)
            begin
                op_reg         <= in_word.opcode;
                key_in_reg     <= in_word.name_key;
                rate_in_reg    <= sat_q15(in_word.ramp_rate);
                lvl_in_reg     <= sat_q15(in_word.level);
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                stop_reg       <= '0;
            end
            if (cmd.scan)
            begin
                if (cur == '0)
                    limit_new_reg <= limit_calc;
                if (!found_reg && mode_reg[cur] != MODE_OFF && key_reg[cur] == key_in_reg)
                begin
                    found_reg      <= 1'b1;
                    found_slot_reg <= cur;
                end
                if (!free_found_reg && mode_reg[cur] == MODE_OFF)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= cur;
                end
            end
            if (cmd.apply)
            begin
                mode_reg[cur]  <= m_n;
                level_reg[cur] <= l_n;
                rate_reg[cur]  <= r_n;
                limit_reg[cur] <= lim_n;
                key_reg[cur]   <= k_n;
                stop_reg[cur]  <= stop_n;
            end
            if (cmd.finish)
            begin
                if (op_reg == OP_SET_VOLUME || op_reg == OP_RESTORE ||
                    (op_reg == OP_MUTE && !muted_reg))
                begin
                    if (do_master)
                        master_reg <= master_v;
                    if (op_reg == OP_MUTE)
                        saved_reg <= master_reg;
                    else
                        saved_reg <= master_v;
                end
                if (op_reg == OP_MUTE)
                    muted_reg <= 1'b1;
                if (op_reg == OP_RESTORE)
                    muted_reg <= 1'b0;
            end
            if (emit)
                out_valid_q <= 1'b1;
            else if (!out_stall)
                out_valid_q <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word.slot_index  <= cmd.slot;
            out_word.slot_mode   <= mode_reg[cur];
            out_word.slot_level  <= level_reg[cur];
            out_word.stopped_now <= stop_reg[cur];
            out_word.status      <= status;
            out_word.is_last     <= (cur == SW'(SLOTS - 1));
        end
    end
endmodule

// ===== rtl/multi_slot_music_fade_controller.sv =====
// ----------------------------------------------------------------------------
// multi_slot_music_fade_controller
// music slot fade controller: one command word in, SLOTS status words out
// ----------------------------------------------------------------------------
// status words follow the command word, one a cycle unless out_stall holds them
// one command in flight; a new word is taken once the last status word is registered
// reset: all slots off, levels zero, master at full scale, fade-all rate 328
module multi_slot_music_fade_controller #(
    parameter int SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  msmfc_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output msmfc_pkg::out_word_t out_data
);
    import msmfc_pkg::*;

    dp_cmd_t cmd;
    logic    emit;

    msmfc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid_q(out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .emit       (emit)
    );

    msmfc_dp #(.SLOTS(SLOTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_word    (in_data),
        .cmd        (cmd),
        .emit       (emit),
        .out_stall  (out_stall),
        .out_valid_q(out_valid),
        .out_word   (out_data)
    );
endmodule
